@@ src/eig2_pkg.sv @@
// Shared types and fixed widths for the 2x2 eigenvalue block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package eig2_pkg;

    // Fixed result and tolerance widths (doubled values carry one extra fraction bit)
    localparam int RE_W  = 27;
    localparam int IM_W  = 25;
    localparam int TOL_W = 48;

    // Side flags that ride along with each item through the root cells
    typedef struct packed {
        logic neg;      // discriminant is negative
        logic im_zero;  // negative, but magnitude below the tolerance
    } eig2_flags_t;

endpackage

`default_nettype wire

@@ src/eig2_front.sv @@
// Front end: trace, squared difference, 4*m01*m10, discriminant, magnitude.
// Four handshaked register stages; depends on eig2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eig2_front
    import eig2_pkg::*;
#(
    parameter int IN_WIDTH = 24,
    parameter int TR_W     = 25,
    parameter int DISC_W   = 50
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic signed [IN_WIDTH-1:0]  m00,
    input  wire logic signed [IN_WIDTH-1:0]  m01,
    input  wire logic signed [IN_WIDTH-1:0]  m10,
    input  wire logic signed [IN_WIDTH-1:0]  m11,
    input  wire logic        [TOL_W-1:0]     tol,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic signed [TR_W-1:0]      out_tr,
    output      logic        [DISC_W-1:0]    out_mag,
    output      eig2_flags_t                 out_flags
);

    localparam int CMP_W = (DISC_W > TOL_W) ? DISC_W : TOL_W;

    // Stage A: trace and difference
    logic                       a_vld_reg;
    logic                       a_rdy;
    logic signed [TR_W-1:0]     a_tr_reg;
    logic signed [TR_W-1:0]     a_diff_reg;
    logic signed [IN_WIDTH-1:0] a_b_reg;
    logic signed [IN_WIDTH-1:0] a_c_reg;
    logic signed [TR_W-1:0]     a_tr_next;
    logic signed [TR_W-1:0]     a_diff_next;

    // Stage B: products
    logic                         b_vld_reg;
    logic                         b_rdy;
    logic signed [TR_W-1:0]       b_tr_reg;
    logic        [DISC_W-1:0]     b_sq_reg;
    logic        [DISC_W-1:0]     b_bc4_reg;
    logic signed [2*TR_W-1:0]     sq_full;
    logic signed [2*IN_WIDTH-1:0] bc_full;
    logic signed [DISC_W-1:0]     bc_ext;
    logic        [DISC_W-1:0]     b_sq_next;
    logic        [DISC_W-1:0]     b_bc4_next;

    // Stage C: discriminant
    logic                   c_vld_reg;
    logic                   c_rdy;
    logic signed [TR_W-1:0] c_tr_reg;
    logic [DISC_W-1:0]      c_disc_reg;
    logic [DISC_W-1:0]      c_disc_next;

    // Stage D: sign, magnitude, tolerance check
    logic                   d_vld_reg;
    logic                   d_rdy;
    logic signed [TR_W-1:0] d_tr_reg;
    logic [DISC_W-1:0]      d_mag_reg;
    eig2_flags_t            d_flags_reg;
    logic [DISC_W-1:0]      d_mag_next;
    eig2_flags_t            d_flags_next;

    assign d_rdy    = !d_vld_reg || out_ready;
    assign c_rdy    = !c_vld_reg || d_rdy;
    assign b_rdy    = !b_vld_reg || c_rdy;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign in_ready = a_rdy;

    assign a_tr_next   = TR_W'(m00) + TR_W'(m11);
    assign a_diff_next = TR_W'(m00) - TR_W'(m11);

    assign sq_full    = a_diff_reg * a_diff_reg;
    assign bc_full    = a_b_reg * a_c_reg;
    assign bc_ext     = DISC_W'(bc_full);
    assign b_sq_next  = sq_full[DISC_W-1:0];
    assign b_bc4_next = {bc_ext[DISC_W-3:0], 2'b00};

    assign c_disc_next = b_sq_reg + b_bc4_reg;

    always_comb
    begin
        d_flags_next.neg     = c_disc_reg[DISC_W-1];
        d_mag_next           = d_flags_next.neg ? (DISC_W'(0) - c_disc_reg) : c_disc_reg;
        d_flags_next.im_zero = d_flags_next.neg && (CMP_W'(d_mag_next) < CMP_W'(tol));
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy) a_vld_reg <= in_valid;
            if (b_rdy) b_vld_reg <= a_vld_reg;
            if (c_rdy) c_vld_reg <= b_vld_reg;
            if (d_rdy) d_vld_reg <= c_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            a_tr_reg   <= a_tr_next;
            a_diff_reg <= a_diff_next;
            a_b_reg    <= m01;
            a_c_reg    <= m10;
        end
        if (b_rdy && a_vld_reg)
        begin
            b_tr_reg  <= a_tr_reg;
            b_sq_reg  <= b_sq_next;
            b_bc4_reg <= b_bc4_next;
        end
        if (c_rdy && b_vld_reg)
        begin
            c_tr_reg   <= b_tr_reg;
            c_disc_reg <= c_disc_next;
        end
        if (d_rdy && c_vld_reg)
        begin
            d_tr_reg    <= c_tr_reg;
            d_mag_reg   <= d_mag_next;
            d_flags_reg <= d_flags_next;
        end
    end

    assign out_valid = d_vld_reg;
    assign out_tr    = d_tr_reg;
    assign out_mag   = d_mag_reg;
    assign out_flags = d_flags_reg;

endmodule

`default_nettype wire

@@ src/eig2_cell.sv @@
// One square-root cell: settles one root bit per item per cycle while out_ready allows.
// Handshaked register stage; depends on eig2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eig2_cell
    import eig2_pkg::*;
#(
    parameter int TR_W   = 25,
    parameter int DISC_W = 50,
    parameter int ROOT_W = 25
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_ready,
    input  wire logic [ROOT_W+1:0]        in_rem,
    input  wire logic [ROOT_W-1:0]        in_root,
    input  wire logic [DISC_W-1:0]        in_mag,
    input  wire logic signed [TR_W-1:0]   in_tr,
    input  wire eig2_flags_t              in_flags,
    output      logic                     out_valid,
    input  wire logic                     out_ready,
    output      logic [ROOT_W+1:0]        out_rem,
    output      logic [ROOT_W-1:0]        out_root,
    output      logic [DISC_W-1:0]        out_mag,
    output      logic signed [TR_W-1:0]   out_tr,
    output      eig2_flags_t              out_flags
);

    localparam int REM_W = ROOT_W + 2;

    logic                   vld_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [DISC_W-1:0]      mag_reg;
    logic signed [TR_W-1:0] tr_reg;
    eig2_flags_t            flags_reg;

    logic [REM_W-1:0]       rem_shift;
    logic [REM_W-1:0]       trial;
    logic                   ge;
    logic [REM_W-1:0]       rem_next;
    logic [ROOT_W-1:0]      root_next;
    logic [DISC_W-1:0]      mag_next;

    // Bring in the next two magnitude bits and try a one in this root bit
    assign rem_shift = {in_rem[REM_W-3:0], in_mag[DISC_W-1 -: 2]};
    assign trial     = {in_root, 2'b01};
    assign ge        = rem_shift >= trial;
    assign rem_next  = ge ? (rem_shift - trial) : rem_shift;
    assign root_next = {in_root[ROOT_W-2:0], ge};
    assign mag_next  = {in_mag[DISC_W-3:0], 2'b00};

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            mag_reg   <= mag_next;
            tr_reg    <= in_tr;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = vld_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_mag   = mag_reg;
    assign out_tr    = tr_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

@@ src/eig2_back.sv @@
// Back end: forms trace +/- root (or trace and an imaginary root), saturates, and holds the result item.
// Output register with handshake; depends on eig2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eig2_back
    import eig2_pkg::*;
#(
    parameter int TR_W   = 25,
    parameter int ROOT_W = 25
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_ready,
    input  wire logic [ROOT_W-1:0]        in_root,
    input  wire logic signed [TR_W-1:0]   in_tr,
    input  wire eig2_flags_t              in_flags,
    output      logic                     out_valid,
    input  wire logic                     out_ready,
    output      logic signed [RE_W-1:0]   re_first_x2,
    output      logic signed [RE_W-1:0]   re_second_x2,
    output      logic        [IM_W-1:0]   im_x2,
    output      logic                     is_complex
);

    localparam int SUM_W = TR_W + 2;
    localparam int EXT_W = (SUM_W > RE_W) ? SUM_W : RE_W;
    localparam int IMX_W = (ROOT_W > IM_W) ? ROOT_W : IM_W;

    localparam logic signed [EXT_W-1:0] RE_MAX = EXT_W'({(RE_W-1){1'b1}});
    localparam logic signed [EXT_W-1:0] RE_MIN = -RE_MAX - EXT_W'(1);
    localparam logic        [IMX_W-1:0] IM_MAX = IMX_W'({IM_W{1'b1}});

    logic                     vld_reg;
    logic signed [RE_W-1:0]   re1_reg;
    logic signed [RE_W-1:0]   re2_reg;
    logic        [IM_W-1:0]   im_reg;
    logic                     cplx_reg;

    logic signed [EXT_W-1:0]  tr_ext;
    logic signed [EXT_W-1:0]  root_ext;
    logic signed [EXT_W-1:0]  sum;
    logic signed [EXT_W-1:0]  dif;
    logic        [IMX_W-1:0]  root_z;
    logic        [IM_W-1:0]   im_sat;
    logic signed [RE_W-1:0]   re1_next;
    logic signed [RE_W-1:0]   re2_next;
    logic        [IM_W-1:0]   im_next;
    logic                     cplx_next;

    function automatic logic signed [RE_W-1:0] sat_re(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] c;
        begin
            if (v > RE_MAX)
                c = RE_MAX;
            else if (v < RE_MIN)
                c = RE_MIN;
            else
                c = v;
            return c[RE_W-1:0];
        end
    endfunction

    assign tr_ext   = EXT_W'(in_tr);
    assign root_ext = EXT_W'({1'b0, in_root});
    assign sum      = tr_ext + root_ext;
    assign dif      = tr_ext - root_ext;
    assign root_z   = IMX_W'(in_root);
    assign im_sat   = (root_z > IM_MAX) ? IM_MAX[IM_W-1:0] : root_z[IM_W-1:0];

    always_comb
    begin
        if (in_flags.neg)
        begin
            re1_next  = sat_re(tr_ext);
            re2_next  = sat_re(tr_ext);
            im_next   = in_flags.im_zero ? '0 : im_sat;
            cplx_next = !in_flags.im_zero;
        end
        else
        begin
            re1_next  = sat_re(sum);
            re2_next  = sat_re(dif);
            im_next   = '0;
            cplx_next = 1'b0;
        end
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            re1_reg  <= re1_next;
            re2_reg  <= re2_next;
            im_reg   <= im_next;
            cplx_reg <= cplx_next;
        end
    end

    assign out_valid    = vld_reg;
    assign re_first_x2  = re1_reg;
    assign re_second_x2 = re2_reg;
    assign im_x2        = im_reg;
    assign is_complex   = cplx_reg;

endmodule

`default_nettype wire

@@ src/eigenvalues_2x2_real_top.sv @@
// Pipeline: ROOT_W + 5 register stages, where ROOT_W is half the discriminant
//   width (IN_WIDTH + 1 up to IN_WIDTH 31, else 32).
//   Four front stages, one root cell per root bit, one output register.
// Throughput: one item per cycle while out_ready is high; every stage holds its
//   own valid bit and fills bubbles while the output is stalled.
// Reset: rst_n clears all valid bits and the tolerance register to zero.
`timescale 1ns / 1ps
`default_nettype none

module eigenvalues_2x2_real_top
    import eig2_pkg::*;
#(
    parameter int IN_WIDTH = 24
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic        [TOL_W-1:0]     cfg_wdata,
    // input items
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic signed [IN_WIDTH-1:0]  m00,
    input  wire logic signed [IN_WIDTH-1:0]  m01,
    input  wire logic signed [IN_WIDTH-1:0]  m10,
    input  wire logic signed [IN_WIDTH-1:0]  m11,
    // result items
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic signed [RE_W-1:0]      re_first_x2,
    output      logic signed [RE_W-1:0]      re_second_x2,
    output      logic        [IM_W-1:0]      im_x2,
    output      logic                        is_complex
);

    // Discriminant holds exactly up to IN_WIDTH 31; beyond that it wraps at 64 bits
    localparam int TR_W   = IN_WIDTH + 1;
    localparam int DISC_W = (2 * IN_WIDTH + 2 > 64) ? 64 : 2 * IN_WIDTH + 2;
    localparam int ROOT_W = DISC_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // Tolerance register; user writes it only while the block is idle; not enforced
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    // Links between stages: index k is the input of root cell k
    logic                   vld_w  [ROOT_W+1];
    logic                   rdy_w  [ROOT_W+1];
    logic [REM_W-1:0]       rem_w  [ROOT_W];
    logic [DISC_W-1:0]      mag_w  [ROOT_W];
    logic [ROOT_W-1:0]      root_w [ROOT_W+1];
    logic signed [TR_W-1:0] tr_w   [ROOT_W+1];
    eig2_flags_t            flg_w  [ROOT_W+1];

    // Front end: trace, discriminant, magnitude and tolerance flag
    eig2_front #(
        .IN_WIDTH (IN_WIDTH),
        .TR_W     (TR_W),
        .DISC_W   (DISC_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .m00       (m00),
        .m01       (m01),
        .m10       (m10),
        .m11       (m11),
        .tol       (tol_reg),
        .out_valid (vld_w[0]),
        .out_ready (rdy_w[0]),
        .out_tr    (tr_w[0]),
        .out_mag   (mag_w[0]),
        .out_flags (flg_w[0])
    );

    // Root search starts from an empty remainder and root
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;

    // Chain of root cells, most significant root bit first
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_cell
        if (k < ROOT_W - 1)
        begin : g_mid
            eig2_cell #(
                .TR_W   (TR_W),
                .DISC_W (DISC_W),
                .ROOT_W (ROOT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (vld_w[k]),
                .in_ready  (rdy_w[k]),
                .in_rem    (rem_w[k]),
                .in_root   (root_w[k]),
                .in_mag    (mag_w[k]),
                .in_tr     (tr_w[k]),
                .in_flags  (flg_w[k]),
                .out_valid (vld_w[k+1]),
                .out_ready (rdy_w[k+1]),
                .out_rem   (rem_w[k+1]),
                .out_root  (root_w[k+1]),
                .out_mag   (mag_w[k+1]),
                .out_tr    (tr_w[k+1]),
                .out_flags (flg_w[k+1])
            );
        end
        else
        begin : g_last
            // Drop the final remainder and the exhausted magnitude bits
            eig2_cell #(
                .TR_W   (TR_W),
                .DISC_W (DISC_W),
                .ROOT_W (ROOT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (vld_w[k]),
                .in_ready  (rdy_w[k]),
                .in_rem    (rem_w[k]),
                .in_root   (root_w[k]),
                .in_mag    (mag_w[k]),
                .in_tr     (tr_w[k]),
                .in_flags  (flg_w[k]),
                .out_valid (vld_w[k+1]),
                .out_ready (rdy_w[k+1]),
                .out_rem   (),
                .out_root  (root_w[k+1]),
                .out_mag   (),
                .out_tr    (tr_w[k+1]),
                .out_flags (flg_w[k+1])
            );
        end
    end

    // Back end: trace plus/minus root, saturation, output register
    eig2_back #(
        .TR_W   (TR_W),
        .ROOT_W (ROOT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld_w[ROOT_W]),
        .in_ready     (rdy_w[ROOT_W]),
        .in_root      (root_w[ROOT_W]),
        .in_tr        (tr_w[ROOT_W]),
        .in_flags     (flg_w[ROOT_W]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .re_first_x2  (re_first_x2),
        .re_second_x2 (re_second_x2),
        .im_x2        (im_x2),
        .is_complex   (is_complex)
    );

endmodule

`default_nettype wire
